// ----- hdl/pmgf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pmgf_pkg
// Shared constants, types and codes of the pulse-rate median gate filter.
// -----------------------------------------------------------------------------
package pmgf_pkg;

   // Window geometry.
   localparam int DEPTH    = 7;
   localparam int FILL_W   = $clog2(DEPTH + 1);
   localparam int MED_IDX  = DEPTH / 2;
   localparam int MED_ODD  = DEPTH % 2;

   // Linear weights of the smoothed rate: WT_BASE + WT_STEP * i, oldest first.
   localparam int WT_BASE  = 10 * (DEPTH - 1);
   localparam int WT_STEP  = 7;
   localparam int WT_MAX   = WT_BASE + WT_STEP * (DEPTH - 1);
   localparam int WT_W     = $clog2(WT_MAX + 1);
   localparam int WT_TOTAL = DEPTH * WT_BASE + WT_STEP * DEPTH * (DEPTH - 1) / 2;
   localparam int TOT_W    = $clog2(WT_TOTAL + 1);

   // Datapath widths.
   localparam int RATE_W   = 16;
   localparam int PROD_W   = RATE_W + WT_W;
   localparam int SUM_W    = RATE_W + TOT_W;
   localparam int NUM_W    = 24;
   localparam int IVL_W    = 12;
   localparam int RATE_NUM = 15360000;
   localparam int DIV_NW   = NUM_W;
   localparam int DIV_DW   = IVL_W;
   localparam int CNT_W    = $clog2(DIV_NW + 1);
   localparam int REJ_W    = 4;
   localparam int REJ_SAT  = 15;

   // Division of the weighted sum by WT_TOTAL as a multiplication by the
   // rounded-up reciprocal; exact for every sum below 2**SUM_W.
   localparam int     RECIP_SH = SUM_W + TOT_W;
   localparam int     RECIP_W  = SUM_W + 1;
   localparam int     MUL_W    = SUM_W + RECIP_W;
   localparam longint RECIP_M  = ((longint'(1) << RECIP_SH) + longint'(WT_TOTAL) - 1)
                                 / longint'(WT_TOTAL);

   typedef enum logic [3:0] {
      STAT_NO_BEAT      = 4'd0,
      STAT_NO_FINGER    = 4'd1,
      STAT_SKIPPED      = 4'd2,
      STAT_FILLING      = 4'd3,
      STAT_WINDOW_FULL  = 4'd4,
      STAT_ACCEPTED     = 4'd5,
      STAT_REJECTED     = 4'd6,
      STAT_REJECT_RESET = 4'd7,
      STAT_ABSENCE      = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RDIV,
      ST_MED,
      ST_MCMP,
      ST_WSUM,
      ST_WDIV,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      REG_BASELINE   = 3'd0,
      REG_ON_DELTA   = 3'd1,
      REG_OFF_DELTA  = 3'd2,
      REG_ABSENCE    = 3'd3,
      REG_MIN_IVL    = 3'd4,
      REG_MAX_IVL    = 3'd5,
      REG_TOLERANCE  = 3'd6,
      REG_MAX_REJ    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic clr;
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

// ----- hdl/pulse_rate_median_gate_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pulse_rate_median_gate_filter
// Finger detection, beat-interval gating, median gate and weighted smoothing
// of an optical pulse rate.
// -----------------------------------------------------------------------------
// Each transaction on the req_ channel is one optical sample and produces
// exactly one transaction on the rsp_ channel. Samples that do not need the
// rate path (no finger, no beat, first beat, interval out of range) load the
// result register in the cycle they are taken, and the next sample can follow at
// once if the result register is free or being taken. A gated beat costs a
// 24-bit division of 15360000 by the interval in the one-bit-per-cycle divider
// (DIV_NW = 24 steps). A beat that only adds to a filling window then goes
// straight to the result. With a full window the division is followed by a
// median scan, a compare, a weighted sum and a reciprocal multiplication for
// the weighted average before the result is loaded; a rejected beat ends after
// the compare, and the beat that completes the window goes from the division
// straight to the weighted sum. The window is a row of DEPTH cells that rotate
// past the head cell during scans and come back in place afterwards.
// -----------------------------------------------------------------------------
module pulse_rate_median_gate_filter
   import pmgf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Sample channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [17:0] req_ir_sample,
   input  wire logic        req_beat_detected,
   input  wire logic [31:0] req_now_ms,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_displayed_rate,
   output logic             rsp_finger_on,
   output logic             rsp_rate_valid,
   output logic [2:0]       rsp_window_fill,
   output logic [3:0]       rsp_status,
   // Register port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers.
   logic [17:0] baseline_ff, on_delta_ff, off_delta_ff;
   logic [15:0] absence_ff, tolerance_ff;
   logic [11:0] min_ivl_ff, max_ivl_ff;
   logic [3:0]  max_rej_ff;
   reg_idx_type csr_idx;
   logic        csr_wr;

   // Block state.
   state_type           state_ff, state_in;
   logic                finger_ff, finger_in;
   logic                armed_ff, armed_in;
   logic [31:0]         abs_start_ff, abs_start_in;
   logic                lbv_ff, lbv_in;
   logic [31:0]         lbt_ff, lbt_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                stab_ff, stab_in;
   logic [REJ_W-1:0]    rej_ff, rej_in;
   logic [RATE_W-1:0]   shown_ff, shown_in;
   status_type          status_ff, status_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [RATE_W-1:0]   med_lo_ff, med_lo_in;
   logic [RATE_W-1:0]   med_hi_ff, med_hi_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                prod_v_ff, prod_v_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [MUL_W-1:0]    wavg_ff, wavg_in;
   logic [RECIP_W-1:0]  recip;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   rsp_rate_ff;
   logic                rsp_finger_ff, rsp_stab_ff;
   logic [2:0]          rsp_fill_ff;
   status_type          rsp_status_ff;

   // Control.
   logic                accept, out_free, out_load;
   logic                go_rate, rate_done, med_done, med_pass, wsum_done;
   logic                win_clr, win_load, win_shift, win_wrap;
   logic                div_start;
   logic [DIV_NW-1:0]   div_num;
   logic [DIV_DW-1:0]   div_den;
   div_stat_type        div_stat;
   logic [DIV_NW-1:0]   div_quo;

   // Sample decode.
   logic [17:0]         delta;
   logic [31:0]         interval, abs_elapsed;
   logic                ivl_ok;
   logic [RATE_W-1:0]   rate_sat;

   // Window cells.
   cell_ctl_type        cell_ctl [DEPTH];
   logic [RATE_W-1:0]   cell_val [DEPTH];
   logic [DEPTH-1:0]    cell_lt, cell_eq;
   logic [FILL_W:0]     cnt_lt, cnt_eq;
   logic [RATE_W:0]     med_sum;
   logic [RATE_W-1:0]   median;
   logic [WT_W-1:0]     weight;
   logic [REJ_W-1:0]    rej_next;

   // ---------------------------------------------------------------------------
   // Register port. Writes land on the access cycle; pready is tied high.
   // ---------------------------------------------------------------------------
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff  <= 18'd0;
         on_delta_ff  <= 18'd8000;
         off_delta_ff <= 18'd4000;
         absence_ff   <= 16'd5000;
         min_ivl_ff   <= 12'd240;
         max_ivl_ff   <= 12'd3000;
         tolerance_ff <= 16'd2560;
         max_rej_ff   <= 4'd5;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_BASELINE:  baseline_ff  <= csr_pwdata[17:0];
            REG_ON_DELTA:  on_delta_ff  <= csr_pwdata[17:0];
            REG_OFF_DELTA: off_delta_ff <= csr_pwdata[17:0];
            REG_ABSENCE:   absence_ff   <= csr_pwdata[15:0];
            REG_MIN_IVL:   min_ivl_ff   <= csr_pwdata[11:0];
            REG_MAX_IVL:   max_ivl_ff   <= csr_pwdata[11:0];
            REG_TOLERANCE: tolerance_ff <= csr_pwdata[15:0];
            REG_MAX_REJ:   max_rej_ff   <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_BASELINE:  csr_prdata = {14'd0, baseline_ff};
         REG_ON_DELTA:  csr_prdata = {14'd0, on_delta_ff};
         REG_OFF_DELTA: csr_prdata = {14'd0, off_delta_ff};
         REG_ABSENCE:   csr_prdata = {16'd0, absence_ff};
         REG_MIN_IVL:   csr_prdata = {20'd0, min_ivl_ff};
         REG_MAX_IVL:   csr_prdata = {20'd0, max_ivl_ff};
         REG_TOLERANCE: csr_prdata = {16'd0, tolerance_ff};
         REG_MAX_REJ:   csr_prdata = {28'd0, max_rej_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Handshake. A sample is taken only in idle, and only when the result
   // register is empty or is being emptied in the same cycle, so a sample that
   // answers at once never overwrites a waiting result.
   // ---------------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && out_free);
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------------
   // Sample decode: finger thresholds and the beat interval gate.
   // ---------------------------------------------------------------------------
   assign delta    = (req_ir_sample > baseline_ff) ? req_ir_sample - baseline_ff : 18'd0;
   assign interval = req_now_ms - lbt_ff;
   assign ivl_ok   = interval > {20'd0, min_ivl_ff} && interval < {20'd0, max_ivl_ff}
                     && interval != 32'd0;
   assign rate_sat = (div_quo > DIV_NW'(16'hFFFF)) ? 16'hFFFF : div_quo[RATE_W-1:0];

   // ---------------------------------------------------------------------------
   // Window: a row of cells. The head cell is the oldest entry; a rotation
   // feeds it back in at the tail so a full scan leaves the order unchanged.
   // ---------------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [RATE_W-1:0] nb;
      if (i == DEPTH - 1) begin : g_tail
         assign nb = win_wrap ? cell_val[0] : rate_ff;
      end else begin : g_body
         assign nb = cell_val[i+1];
      end
      assign cell_ctl[i].clr   = win_clr;
      assign cell_ctl[i].shift = win_shift;
      assign cell_ctl[i].load  = win_load && (fill_ff == FILL_W'(i));
      pmgf_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .load_val (rate_sat),
         .shift_in (nb),
         .cand     (cell_val[0]),
         .value    (cell_val[i]),
         .lt       (cell_lt[i]),
         .eq       (cell_eq[i])
      );
   end

   always_comb begin
      cnt_lt = '0;
      cnt_eq = '0;
      for (int k = 0; k < DEPTH; k++) begin
         cnt_lt = cnt_lt + (FILL_W + 1)'(cell_lt[k]);
         cnt_eq = cnt_eq + (FILL_W + 1)'(cell_eq[k]);
      end
   end

   assign med_sum = {1'b0, med_lo_ff} + {1'b0, med_hi_ff};
   assign median  = (MED_ODD != 0) ? med_hi_ff : med_sum[RATE_W:1];
   assign med_pass = ({1'b0, rate_ff} + {1'b0, tolerance_ff} >= {1'b0, median})
                     && ({1'b0, rate_ff} <= {1'b0, median} + {1'b0, tolerance_ff});
   assign weight  = WT_W'(WT_BASE + WT_STEP * int'(step_ff));
   assign rej_next = (rej_ff < REJ_W'(REJ_SAT)) ? rej_ff + 1'b1 : rej_ff;
   assign recip    = RECIP_W'(RECIP_M);

   assign go_rate   = finger_in && req_beat_detected && lbv_ff && ivl_ok;
   assign rate_done = state_ff == ST_RDIV && div_stat.done;
   assign med_done  = step_ff == CNT_W'(DEPTH - 1);
   assign wsum_done = step_ff == CNT_W'(DEPTH);

   // ---------------------------------------------------------------------------
   // Next state.
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && go_rate) begin
               state_in = ST_RDIV;
            end
         end
         ST_RDIV: begin
            if (div_stat.done) begin
               if (stab_ff) begin
                  state_in = ST_MED;
               end else if (fill_ff == FILL_W'(DEPTH - 1)) begin
                  state_in = ST_WSUM;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MED: begin
            if (med_done) begin
               state_in = ST_MCMP;
            end
         end
         ST_MCMP: state_in = med_pass ? ST_WSUM : ST_FIN;
         ST_WSUM: begin
            if (wsum_done) begin
               state_in = ST_WDIV;
            end
         end
         ST_WDIV: begin
            if (step_ff == CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // State updates and control outputs.
   // ---------------------------------------------------------------------------
   always_comb begin
      finger_in    = finger_ff;
      armed_in     = armed_ff;
      abs_start_in = abs_start_ff;
      lbv_in       = lbv_ff;
      lbt_in       = lbt_ff;
      fill_in      = fill_ff;
      stab_in      = stab_ff;
      rej_in       = rej_ff;
      shown_in     = shown_ff;
      status_in    = status_ff;
      rate_in      = rate_ff;
      med_lo_in    = med_lo_ff;
      med_hi_in    = med_hi_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      prod_v_in    = 1'b0;
      acc_in       = acc_ff;
      wavg_in      = wavg_ff;
      abs_elapsed  = 32'd0;
      win_clr      = 1'b0;
      win_load     = 1'b0;
      win_shift    = 1'b0;
      win_wrap     = 1'b0;
      div_start    = 1'b0;
      div_num      = DIV_NW'(RATE_NUM);
      div_den      = DIV_DW'(interval[IVL_W-1:0]);
      out_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!finger_ff) begin
                  if (delta > on_delta_ff) begin
                     finger_in    = 1'b1;
                     armed_in     = 1'b0;
                     abs_start_in = 32'd0;
                  end else begin
                     armed_in = 1'b1;
                     if (!armed_ff) begin
                        abs_start_in = req_now_ms;
                     end
                     status_in   = STAT_NO_FINGER;
                     abs_elapsed = req_now_ms - abs_start_in;
                     if (abs_elapsed >= {16'd0, absence_ff}) begin
                        // Long absence clears the whole measurement.
                        lbv_in       = 1'b0;
                        lbt_in       = 32'd0;
                        win_clr      = 1'b1;
                        fill_in      = '0;
                        stab_in      = 1'b0;
                        rej_in       = '0;
                        shown_in     = '0;
                        abs_start_in = req_now_ms;
                        status_in    = STAT_ABSENCE;
                     end
                  end
               end else if (delta < off_delta_ff) begin
                  finger_in    = 1'b0;
                  armed_in     = 1'b1;
                  abs_start_in = req_now_ms;
                  status_in    = STAT_NO_FINGER;
               end
               if (finger_in) begin
                  status_in = STAT_NO_BEAT;
                  if (req_beat_detected) begin
                     status_in = STAT_SKIPPED;
                     lbt_in    = req_now_ms;
                     lbv_in    = 1'b1;
                  end
               end
               if (go_rate) begin
                  div_start = 1'b1;
               end else begin
                  out_load = 1'b1;
               end
            end
         end
         ST_RDIV: begin
            if (div_stat.done) begin
               rate_in = rate_sat;
               step_in = '0;
               acc_in  = '0;
               if (!stab_ff) begin
                  win_load  = 1'b1;
                  fill_in   = fill_ff + 1'b1;
                  status_in = STAT_FILLING;
                  if (fill_ff == FILL_W'(DEPTH - 1)) begin
                     stab_in   = 1'b1;
                     rej_in    = '0;
                     status_in = STAT_WINDOW_FULL;
                  end
               end
            end
         end
         ST_MED: begin
            // The head cell is the candidate; its rank among all entries
            // tells whether it sits at one of the middle places.
            win_shift = 1'b1;
            win_wrap  = 1'b1;
            step_in   = step_ff + 1'b1;
            if (cnt_lt <= (FILL_W + 1)'(MED_IDX)
                && (FILL_W + 1)'(MED_IDX) < cnt_lt + cnt_eq) begin
               med_hi_in = cell_val[0];
            end
            if (cnt_lt <= (FILL_W + 1)'(MED_IDX - 1)
                && (FILL_W + 1)'(MED_IDX - 1) < cnt_lt + cnt_eq) begin
               med_lo_in = cell_val[0];
            end
            if (med_done) begin
               step_in = '0;
            end
         end
         ST_MCMP: begin
            if (med_pass) begin
               win_shift = 1'b1;
               rej_in    = '0;
               status_in = STAT_ACCEPTED;
            end else begin
               rej_in    = rej_next;
               status_in = STAT_REJECTED;
               if (rej_next >= max_rej_ff) begin
                  // The beat time just stored survives this clear.
                  win_clr   = 1'b1;
                  fill_in   = '0;
                  stab_in   = 1'b0;
                  rej_in    = '0;
                  shown_in  = '0;
                  status_in = STAT_REJECT_RESET;
               end
            end
         end
         ST_WSUM: begin
            // One product a cycle into a register, summed in the next cycle.
            step_in = step_ff + 1'b1;
            if (!wsum_done) begin
               win_shift = 1'b1;
               win_wrap  = 1'b1;
               prod_in   = PROD_W'(cell_val[0] * weight);
               prod_v_in = 1'b1;
            end else begin
               step_in = '0;
            end
            if (prod_v_ff) begin
               acc_in = acc_ff + SUM_W'(prod_ff);
            end
         end
         ST_WDIV: begin
            // The weighted sum times the reciprocal of the weight total; the
            // quotient is the product shifted down by RECIP_SH.
            if (step_ff == '0) begin
               wavg_in = MUL_W'(acc_ff) * MUL_W'(recip);
               step_in = CNT_W'(1);
            end else begin
               shown_in = wavg_ff[RECIP_SH +: RATE_W];
               step_in  = '0;
            end
         end
         ST_FIN: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   pmgf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------------------
   // Result register.
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         finger_ff    <= 1'b0;
         armed_ff     <= 1'b0;
         abs_start_ff <= 32'd0;
         lbv_ff       <= 1'b0;
         lbt_ff       <= 32'd0;
         fill_ff      <= '0;
         stab_ff      <= 1'b0;
         rej_ff       <= '0;
         shown_ff     <= '0;
         prod_v_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         finger_ff    <= finger_in;
         armed_ff     <= armed_in;
         abs_start_ff <= abs_start_in;
         lbv_ff       <= lbv_in;
         lbt_ff       <= lbt_in;
         fill_ff      <= fill_in;
         stab_ff      <= stab_in;
         rej_ff       <= rej_in;
         shown_ff     <= shown_in;
         prod_v_ff    <= prod_v_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      rate_ff   <= rate_in;
      med_lo_ff <= med_lo_in;
      med_hi_ff <= med_hi_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      wavg_ff   <= wavg_in;
      if (out_load) begin
         rsp_rate_ff   <= shown_in;
         rsp_finger_ff <= finger_in;
         rsp_stab_ff   <= stab_in;
         rsp_fill_ff   <= fill_in[2:0];
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_displayed_rate = rsp_rate_ff;
   assign rsp_finger_on      = rsp_finger_ff;
   assign rsp_rate_valid     = rsp_stab_ff;
   assign rsp_window_fill    = rsp_fill_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
`default_nettype wire

// ----- hdl/pmgf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pmgf_cell
// One window entry: holds a rate, takes its neighbor's value on a shift and
// compares itself with the broadcast candidate.
// -----------------------------------------------------------------------------
module pmgf_cell
   import pmgf_pkg::*;
(
   input  wire logic               clock,
   input  wire cell_ctl_type       ctl,
   input  wire logic [RATE_W-1:0]  load_val,
   input  wire logic [RATE_W-1:0]  shift_in,
   input  wire logic [RATE_W-1:0]  cand,
   output logic      [RATE_W-1:0]  value,
   output logic                    lt,
   output logic                    eq
);

   logic [RATE_W-1:0] value_ff;
   logic [RATE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.clr) begin
         value_in = '0;
      end else if (ctl.load) begin
         value_in = load_val;
      end else if (ctl.shift) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign lt    = value_ff < cand;
   assign eq    = value_ff == cand;

endmodule
`default_nettype wire

// ----- hdl/pmgf_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pmgf_div
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module pmgf_div
   import pmgf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_NW-1:0] dividend,
   input  wire logic [DIV_DW-1:0] divisor,
   output div_stat_type           stat,
   output logic      [DIV_NW-1:0] quotient
);

   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] dsr_ff, dsr_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DIV_NW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
         quo_in = {quo_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

// ----- hdl/pmgf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pmgf_checker
// Port-level checks of the pulse-rate median gate filter.
// -----------------------------------------------------------------------------
module pmgf_checker
   import pmgf_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_finger_on,
   input wire logic        rsp_rate_valid,
   input wire logic [2:0]  rsp_window_fill,
   input wire logic [3:0]  rsp_status
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result changed while stalled");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rate_valid |-> rsp_window_fill == 3'(DEPTH))
      else $error("stabilized rate without a full window");

   a_nofinger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NO_FINGER || rsp_status == STAT_ABSENCE)
      |-> !rsp_finger_on)
      else $error("finger reported on an absence status");

   a_stab: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_ACCEPTED || rsp_status == STAT_WINDOW_FULL)
      |-> rsp_rate_valid)
      else $error("accepted rate while not stabilized");

endmodule

bind pulse_rate_median_gate_filter pmgf_checker u_pmgf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_finger_on   (rsp_finger_on),
   .rsp_rate_valid  (rsp_rate_valid),
   .rsp_window_fill (rsp_window_fill),
   .rsp_status      (rsp_status)
);
`default_nettype wire
